### src/rgbfb_pkg.sv
// Package with the shared types, register indexes and limits of the RGB24 framebuffer blitter.
`timescale 1ns / 1ps

package rgbfb_pkg;

    localparam logic [12:0] MAX_COLS = 13'd4096;
    localparam logic [11:0] MAX_ROWS = 12'd2048;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_BUFFER_STRIDE = 3'd2;
    localparam logic [2:0] CFG_WIN_X_LO      = 3'd3;
    localparam logic [2:0] CFG_WIN_X_HI      = 3'd4;
    localparam logic [2:0] CFG_WIN_Y_LO      = 3'd5;
    localparam logic [2:0] CFG_WIN_Y_HI      = 3'd6;

    localparam logic [1:0] PHASE_BLUE = 2'd2;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [11:0] start_col;
        logic [10:0] start_row;
    } byte_item_t;

    typedef struct packed {
        logic [22:0] fb_address;
        logic [23:0] pixel_color;
    } pixel_item_t;

endpackage

### src/rgbfb_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
`timescale 1ns / 1ps

interface rgbfb_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

### src/rgb24_to_framebuffer_blitter.sv
// Top level of the RGB24 to framebuffer blitter: byte packing, position tracking and addressing.
// A blue byte's pixel goes through the position/packing register and then the address register.
// Throughput: one byte transaction per cycle while the pixel output is not stalled; the stages are
// the position/packing register and the address register, which multiplies row by stride and adds
// the column. Reset clears the byte phase, the position counters, the image end flag and both valid
// flags, and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module rgb24_to_framebuffer_blitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    rgbfb_stream_if.sink         byte_stream,
    rgbfb_stream_if.source       pixel_stream
);

    logic [12:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [12:0] buffer_stride_reg;
    logic [12:0] win_x_lo_reg;
    logic [12:0] win_x_hi_reg;
    logic [11:0] win_y_lo_reg;
    logic [11:0] win_y_hi_reg;

    logic [1:0]  byte_phase_reg, byte_phase_next;
    logic [7:0]  held_reg [2];
    logic [11:0] col_count_reg, col_count_next;
    logic [10:0] row_count_reg, row_count_next;
    logic        image_done_reg, image_done_next;

    logic        pix_valid_reg;
    logic [11:0] pix_col_reg;
    logic [10:0] pix_row_reg;
    logic [23:0] pix_color_reg;

    logic        out_valid_reg;
    logic [22:0] out_address_reg;
    logic [23:0] out_color_reg;

    logic [12:0] width_eff;
    logic [11:0] height_eff;
    logic        in_fire;
    logic        out_load;
    logic        pix_advance;
    logic        held_write;
    logic        pix_hit;
    logic [12:0] col_inc;
    logic [11:0] row_inc;
    logic        in_window;
    logic [23:0] row_base;
    logic [24:0] address_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 13'd1920;
            image_height_reg  <= 12'd1080;
            buffer_stride_reg <= 13'd1920;
            win_x_lo_reg      <= 13'd0;
            win_x_hi_reg      <= 13'd1920;
            win_y_lo_reg      <= 12'd0;
            win_y_hi_reg      <= 12'd1080;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rgbfb_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                rgbfb_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[11:0];
                rgbfb_pkg::CFG_BUFFER_STRIDE: buffer_stride_reg <= cfg_data;
                rgbfb_pkg::CFG_WIN_X_LO:      win_x_lo_reg      <= cfg_data;
                rgbfb_pkg::CFG_WIN_X_HI:      win_x_hi_reg      <= cfg_data;
                rgbfb_pkg::CFG_WIN_Y_LO:      win_y_lo_reg      <= cfg_data[11:0];
                rgbfb_pkg::CFG_WIN_Y_HI:      win_y_hi_reg      <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    assign width_eff  = (image_width_reg < rgbfb_pkg::MAX_COLS) ? image_width_reg
                                                                 : rgbfb_pkg::MAX_COLS;
    assign height_eff = (image_height_reg < rgbfb_pkg::MAX_ROWS) ? image_height_reg
                                                                  : rgbfb_pkg::MAX_ROWS;

    assign out_load    = !out_valid_reg || pixel_stream.ready;
    assign pix_advance = !pix_valid_reg || out_load;
    assign byte_stream.ready = pix_advance;
    assign in_fire     = byte_stream.valid && pix_advance;

    assign col_inc   = 13'(col_count_reg) + 13'd1;
    assign row_inc   = 12'(row_count_reg) + 12'd1;
    assign in_window = (13'(col_count_reg) >= win_x_lo_reg) && (13'(col_count_reg) < win_x_hi_reg)
                    && (12'(row_count_reg) >= win_y_lo_reg) && (12'(row_count_reg) < win_y_hi_reg);

    always_comb
    begin
        byte_phase_next = byte_phase_reg;
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        image_done_next = image_done_reg;
        held_write      = 1'b0;
        pix_hit         = 1'b0;
        if (in_fire)
        begin
            if (byte_stream.payload.op == rgbfb_pkg::OP_START)
            begin
                byte_phase_next = 2'd0;
                if ((13'(byte_stream.payload.start_col) >= width_eff)
                    || (12'(byte_stream.payload.start_row) >= height_eff))
                begin
                    col_count_next  = 12'd0;
                    row_count_next  = 11'd0;
                    image_done_next = 1'b1;
                end
                else
                begin
                    col_count_next  = byte_stream.payload.start_col;
                    row_count_next  = byte_stream.payload.start_row;
                    image_done_next = 1'b0;
                end
            end
            else if (!image_done_reg)
            begin
                if (byte_phase_reg != rgbfb_pkg::PHASE_BLUE)
                begin
                    held_write      = 1'b1;
                    byte_phase_next = byte_phase_reg + 2'd1;
                end
                else
                begin
                    byte_phase_next = 2'd0;
                    pix_hit         = in_window;
                    if (col_inc >= width_eff)
                    begin
                        col_count_next = 12'd0;
                        if (row_inc >= height_eff)
                        begin
                            row_count_next  = 11'd0;
                            image_done_next = 1'b1;
                        end
                        else
                        begin
                            row_count_next = row_inc[10:0];
                        end
                    end
                    else
                    begin
                        col_count_next = col_inc[11:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg <= 2'd0;
            col_count_reg  <= 12'd0;
            row_count_reg  <= 11'd0;
            image_done_reg <= 1'b0;
            pix_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_phase_reg <= byte_phase_next;
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            image_done_reg <= image_done_next;
            if (pix_advance)
            begin
                pix_valid_reg <= pix_hit;
            end
            if (out_load)
            begin
                out_valid_reg <= pix_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (held_write)
        begin
            held_reg[byte_phase_reg[0]] <= byte_stream.payload.data_byte;
        end
        if (pix_hit)
        begin
            pix_col_reg   <= col_count_reg;
            pix_row_reg   <= row_count_reg;
            pix_color_reg <= {held_reg[0], held_reg[1], byte_stream.payload.data_byte};
        end
        if (out_load && pix_valid_reg)
        begin
            out_address_reg <= address_sum[22:0];
            out_color_reg   <= pix_color_reg;
        end
    end

    assign row_base    = 24'(pix_row_reg) * 24'(buffer_stride_reg);
    assign address_sum = 25'(row_base) + 25'(pix_col_reg);

    assign pixel_stream.valid               = out_valid_reg;
    assign pixel_stream.payload.fb_address  = out_address_reg;
    assign pixel_stream.payload.pixel_color = out_color_reg;

    // The byte phase only counts red and green before the blue byte completes a pixel.
    assert property (@(posedge clk) disable iff (!rst_n) byte_phase_reg != 2'd3)
        else $error("byte phase left its range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_stream.payload.op == rgbfb_pkg::OP_START) |=> byte_phase_reg == 2'd0)
        else $error("start transaction did not clear the byte phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && image_done_reg && byte_stream.payload.op == rgbfb_pkg::OP_DATA)
        |=> !pix_valid_reg)
        else $error("pixel produced after the image end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_phase_reg != rgbfb_pkg::PHASE_BLUE) |=> !pix_valid_reg)
        else $error("pixel produced before its blue byte");

    assert property (@(posedge clk) disable iff (!rst_n) !pix_valid_reg |-> byte_stream.ready)
        else $error("input stalled with an empty pixel stage");

endmodule
